// File: rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg: calendar date advance shared types and helpers
// Item structs, command codes, sequencer states and calendar functions used
// by the date advance block.
// ----------------------------------------------------------------------------
package cda_pkg;

   // Command codes
   localparam logic [1:0] CMD_ADD_DAYS   = 2'd0;
   localparam logic [1:0] CMD_ADD_MONTHS = 2'd1;
   localparam logic [1:0] CMD_ADD_YEARS  = 2'd2;

   // Calendar limits
   localparam logic [16:0] YEAR_MAX       = 17'd9999;
   localparam logic [16:0] YEAR_MIN_VALID = 17'd1990;
   localparam logic [8:0]  DAYS_LEAP      = 9'd366;
   localparam logic [8:0]  DAYS_COMMON    = 9'd365;
   localparam logic [6:0]  YY_LAST        = 7'd99;

   // Reciprocals: x / 100 = (x * 5243) >> 19 for x < 43690,
   //              x / 12  = (x * 174763) >> 21 for x < 2**19
   localparam logic [17:0] RECIP_100 = 18'd5243;
   localparam logic [17:0] RECIP_12  = 18'd174763;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [13:0] start_year;
      logic [15:0] amount;
   } req_type;

   typedef struct packed {
      logic [4:0]  new_day;
      logic [3:0]  new_month;
      logic [13:0] new_year;
      logic        start_valid;
      logic        year_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_SETUP,
      ST_YEARS,
      ST_MONTHS,
      ST_MUL12,
      ST_MQUOT,
      ST_FINISH
   } state_type;

   // Leap year from year mod 100 and (year / 100) mod 4
   function automatic logic is_leap(input logic [6:0] yy, input logic [1:0] c4);
      is_leap = (yy[1:0] == 2'd0) && ((yy != 7'd0) || (c4 == 2'd0));
   endfunction

   // Length of a month; codes outside 1 to 12 mean nothing here
   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      case (m)
         4'd2: begin
            month_days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            month_days = 5'd30;
         end
         default: begin
            month_days = 5'd31;
         end
      endcase
   endfunction

endpackage

// File: rtl/calendar_date_advance.sv
// ----------------------------------------------------------------------------
// calendar_date_advance: Gregorian date advance
// Advances a date by a number of days, months or years and checks the
// starting date. A small sequencer steps one shared add/compare datapath
// and one shared multiplier.
// ----------------------------------------------------------------------------
//
//   channel  ports                            direction  carries
//   req      req_valid req_ready req_data     in         cmd, date, amount
//   rsp      rsp_valid rsp_ready rsp_data     out        date, valid, overflow
//
// An item passes through SPLIT and SETUP. Adding years or passing a date through
// then goes to FINISH, adding months goes through MUL12 and MQUOT, and adding
// days loops in YEARS, one whole year skipped per step, and in MONTHS, one
// month step at a time, before FINISH. The block holds one item at a time. A finished
// item waits in the output register, so the next item is accepted while it is stalled.
// Reset is synchronous and active high and clears the sequencer and rsp_valid.
module calendar_date_advance (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cda_pkg::rsp_type rsp_data
);

   // Sequencer and working registers
   cda_pkg::state_type state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [16:0] year_ff, year_in;
   logic [16:0] rem_ff, rem_in;
   logic [6:0]  yy_ff, yy_in;
   logic [1:0]  c4_ff, c4_in;
   logic [34:0] prod_ff, prod_in;
   logic        valid_ff, valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   cda_pkg::rsp_type rsp_ff, rsp_in;

   // Shared datapath signals
   logic [16:0] mul_a;
   logic [17:0] mul_b;
   logic        leap_cur;
   logic [8:0]  year_days;
   logic [4:0]  mon_days;
   logic [16:0] year_inc;
   logic [6:0]  yy_inc;
   logic [1:0]  c4_inc;
   logic [7:0]  cent;
   logic [14:0] yy_wide;
   logic [6:0]  yy_start;
   logic        leap_start;
   logic        month_ok;
   logic [17:0] day_sum;
   logic [12:0] q12;
   logic [16:0] r12;
   logic        out_free;

   // Current-year calendar facts
   assign leap_cur  = cda_pkg::is_leap(yy_ff, c4_ff);
   assign year_days = leap_cur ? cda_pkg::DAYS_LEAP : cda_pkg::DAYS_COMMON;
   assign mon_days  = cda_pkg::month_days(month_ff, leap_cur);
   assign month_ok  = (month_ff >= 4'd1) && (month_ff <= 4'd12);

   // Advance the year together with its mod 100 and century mod 4
   assign year_inc = year_ff + 17'd1;
   assign yy_inc   = (yy_ff == cda_pkg::YY_LAST) ? 7'd0 : yy_ff + 7'd1;
   assign c4_inc   = (yy_ff == cda_pkg::YY_LAST) ? c4_ff + 2'd1 : c4_ff;

   // Split the start year into century and year of century
   assign cent       = prod_ff[26:19];
   assign yy_wide    = {1'b0, year_ff[13:0]} - ({7'd0, cent} * 15'd100);
   assign yy_start   = yy_wide[6:0];
   assign leap_start = cda_pkg::is_leap(yy_start, cent[1:0]);

   // Day step and month quotient
   assign day_sum = {1'b0, rem_ff} + {13'd0, day_ff};
   assign q12     = prod_ff[33:21];
   assign r12     = rem_ff - ({4'd0, q12} * 17'd12);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Shared multiplier operand select
   always_comb begin
      if (state_ff == cda_pkg::ST_MUL12) begin
         mul_a = rem_ff;
         mul_b = cda_pkg::RECIP_12;
      end else begin
         mul_a = year_ff;
         mul_b = cda_pkg::RECIP_100;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cda_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cda_pkg::ST_SPLIT;
            end
         end
         cda_pkg::ST_SPLIT: begin
            state_in = cda_pkg::ST_SETUP;
         end
         cda_pkg::ST_SETUP: begin
            if (cmd_ff == cda_pkg::CMD_ADD_DAYS && month_ok) begin
               state_in = cda_pkg::ST_YEARS;
            end else if (cmd_ff == cda_pkg::CMD_ADD_MONTHS && month_ok) begin
               state_in = cda_pkg::ST_MUL12;
            end else begin
               state_in = cda_pkg::ST_FINISH;
            end
         end
         cda_pkg::ST_YEARS: begin
            if (rem_ff < {8'd0, year_days}) begin
               state_in = cda_pkg::ST_MONTHS;
            end
         end
         cda_pkg::ST_MONTHS: begin
            if (day_sum <= {13'd0, mon_days}) begin
               state_in = cda_pkg::ST_FINISH;
            end
         end
         cda_pkg::ST_MUL12: begin
            state_in = cda_pkg::ST_MQUOT;
         end
         cda_pkg::ST_MQUOT: begin
            state_in = cda_pkg::ST_FINISH;
         end
         cda_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = cda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cda_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath updates per state
   always_comb begin
      cmd_in       = cmd_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      rem_in       = rem_ff;
      yy_in        = yy_ff;
      c4_in        = c4_ff;
      valid_in     = valid_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         cda_pkg::ST_IDLE: begin
            // load the item
            cmd_in   = req_data.cmd;
            day_in   = req_data.start_day;
            month_in = req_data.start_month;
            year_in  = {3'd0, req_data.start_year};
            rem_in   = {1'b0, req_data.amount};
         end
         cda_pkg::ST_SPLIT: begin
            prod_in = {17'd0, mul_a} * {17'd0, mul_b};
         end
         cda_pkg::ST_SETUP: begin
            // check the start date and dispatch on the command
            yy_in    = yy_start;
            c4_in    = cent[1:0];
            valid_in = month_ok && (year_ff >= cda_pkg::YEAR_MIN_VALID) &&
                       (day_ff != 5'd0) &&
                       (day_ff <= cda_pkg::month_days(month_ff, leap_start));
            if (cmd_ff == cda_pkg::CMD_ADD_MONTHS) begin
               rem_in = rem_ff + {13'd0, month_ff} - 17'd1;
            end else if (cmd_ff == cda_pkg::CMD_ADD_YEARS) begin
               year_in = year_ff + rem_ff;
            end
         end
         cda_pkg::ST_YEARS: begin
            // skip one whole year
            if (rem_ff >= {8'd0, year_days}) begin
               rem_in  = rem_ff - {8'd0, year_days};
               year_in = year_inc;
               yy_in   = yy_inc;
               c4_in   = c4_inc;
            end
         end
         cda_pkg::ST_MONTHS: begin
            // use up the rest of the month, or land on the final day
            if (day_sum > {13'd0, mon_days}) begin
               rem_in = 17'(day_sum - {13'd0, mon_days} - 18'd1);
               day_in = 5'd1;
               if (month_ff == 4'd12) begin
                  month_in = 4'd1;
                  year_in  = year_inc;
                  yy_in    = yy_inc;
                  c4_in    = c4_inc;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               day_in = day_sum[4:0];
            end
         end
         cda_pkg::ST_MUL12: begin
            prod_in = {17'd0, mul_a} * {17'd0, mul_b};
         end
         cda_pkg::ST_MQUOT: begin
            year_in  = year_ff + {4'd0, q12};
            month_in = r12[3:0] + 4'd1;
         end
         cda_pkg::ST_FINISH: begin
            // saturate and hand the item to the output register
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.new_day        = day_ff;
               rsp_in.new_month      = month_ff;
               rsp_in.start_valid    = valid_ff;
               rsp_in.year_overflow  = (year_ff > cda_pkg::YEAR_MAX);
               rsp_in.new_year       = (year_ff > cda_pkg::YEAR_MAX) ?
                                       cda_pkg::YEAR_MAX[13:0] : year_ff[13:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      rem_ff   <= rem_in;
      yy_ff    <= yy_in;
      c4_ff    <= c4_in;
      prod_ff  <= prod_in;
      valid_ff <= valid_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == cda_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted item keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready right after accepting an item");

   // Overflow flag goes with a saturated year
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.year_overflow |-> rsp_data.new_year == 14'd9999)
      else $error("overflow without saturated year");

   // A valid start date always gives a month in range
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_valid |->
         rsp_data.new_month >= 4'd1 && rsp_data.new_month <= 4'd12)
      else $error("result month out of range for a valid start date");

endmodule
